### rtl/core/cpu_debug_handshake_controller_macros.svh
// Assertion macros used by the debug-port controller checker.
`ifndef CPU_DEBUG_HANDSHAKE_CONTROLLER_MACROS_SVH
`define CPU_DEBUG_HANDSHAKE_CONTROLLER_MACROS_SVH

// Check a property on the rising clock edge, idle while reset is high.
`define CDHC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Default form: clock named clock, reset named reset.
`define CDHC_ASSERT(label, prop, msg) \
   `CDHC_ASSERT_RST(label, clock, reset, prop, msg)

`endif

### rtl/core/cdhc_pkg.sv
// Types and codes of the debug-port handshake controller.
package cdhc_pkg;

   localparam int NumRegs = 12;

   typedef logic [2:0]  command_type;
   typedef logic [7:0]  byte_type;
   typedef logic [3:0]  reg_sel_type;
   typedef logic [1:0]  code_type;
   typedef logic [15:0] reg_word_type;
   typedef logic [2:0]  dbg_state_type;
   typedef logic [4:0]  byte_index_type;

   // event codes
   localparam command_type CmdHalt     = 3'd0;
   localparam command_type CmdBreak    = 3'd1;
   localparam command_type CmdContinue = 3'd2;
   localparam command_type CmdReport   = 3'd3;
   localparam command_type CmdPortRead = 3'd4;
   localparam command_type CmdPortWr   = 3'd5;
   localparam command_type CmdPoll     = 3'd6;
   localparam command_type CmdQuery    = 3'd7;

   // session state codes as shown on debug_state
   localparam dbg_state_type DbgNone      = 3'd0;
   localparam dbg_state_type DbgHandshake = 3'd1;
   localparam dbg_state_type DbgGetStatus = 3'd2;
   localparam dbg_state_type DbgGetRegs   = 3'd3;
   localparam dbg_state_type DbgReceiving = 3'd4;
   localparam dbg_state_type DbgPrintRegs = 3'd5;
   localparam dbg_state_type DbgPause     = 3'd6;

   // command byte returned on a port read
   localparam code_type PortNone      = 2'd0;
   localparam code_type PortPause     = 2'd1;
   localparam code_type PortDumpRegs  = 2'd2;
   localparam code_type PortGetStatus = 2'd3;

   localparam code_type NmiNone  = 2'd0;
   localparam code_type NmiPulse = 2'd1;
   localparam code_type NmiHold  = 2'd2;

   localparam code_type IrqKeep    = 2'd0;
   localparam code_type IrqDisable = 2'd1;
   localparam code_type IrqEnable  = 2'd2;

   localparam code_type MsgNone      = 2'd0;
   localparam code_type MsgRegsReady = 2'd1;
   localparam code_type MsgPaused    = 2'd2;
   localparam code_type MsgRunning   = 2'd3;

   // remote status bytes
   localparam byte_type StatusDumpRegs   = 8'h01;
   localparam byte_type StatusStopped    = 8'h02;
   localparam byte_type StatusBreakpoint = 8'h04;
   localparam byte_type StatusFinished   = 8'hFF;

   localparam byte_index_type LastByte = 5'd24;

endpackage

### rtl/core/cdhc_req_if.sv
// Request channel of the debug-port controller.
interface cdhc_req_if import cdhc_pkg::*; ();
   logic        valid;
   logic        ready;
   command_type command;
   byte_type    data_byte;
   reg_sel_type reg_select;
   logic        reset_active;
   logic        bus_acquiring;

   modport source (output valid, command, data_byte, reg_select, reset_active,
                   bus_acquiring, input ready);
   modport sink (input valid, command, data_byte, reg_select, reset_active,
                 bus_acquiring, output ready);
   modport monitor (input valid, ready, command, data_byte, reg_select,
                    reset_active, bus_acquiring);
endinterface

### rtl/core/cdhc_rsp_if.sv
// Response channel of the debug-port controller.
interface cdhc_rsp_if import cdhc_pkg::*; ();
   logic          valid;
   logic          ready;
   code_type      port_data;
   code_type      nmi_action;
   code_type      irq_action;
   code_type      message;
   byte_type      status_byte;
   reg_word_type  reg_value;
   dbg_state_type debug_state;
   logic          capture_done;

   modport source (output valid, port_data, nmi_action, irq_action, message,
                   status_byte, reg_value, debug_state, capture_done, input ready);
   modport sink (input valid, port_data, nmi_action, irq_action, message,
                 status_byte, reg_value, debug_state, capture_done, output ready);
   modport monitor (input valid, ready, port_data, nmi_action, irq_action, message,
                    status_byte, reg_value, debug_state, capture_done);
endinterface

### rtl/core/cpu_debug_handshake_controller.sv
// Top level of the debug-port handshake controller.
//
//   channel   dir  handshake      contents
//   req_chan  in   valid/ready    event command, port byte, register select, gates
//   rsp_chan  out  valid/ready    port byte, NMI/IRQ actions, message, status, register
//
// One request per cycle while the response is taken; each passes from acceptance to response
// through the request register, then the response register, set by the single state update.
// Reset clears the session, byte index, status, shown message and all captured regs.
// A stalled response holds its register; the request register still drains into it
// in the cycle the response is taken, so no bubble appears under steady flow.
module cpu_debug_handshake_controller import cdhc_pkg::*; (
   input logic         clock,
   input logic         reset,
   cdhc_req_if.sink    req_chan,
   cdhc_rsp_if.source  rsp_chan
);

   typedef enum logic [2:0] {
      ST_NONE      = DbgNone,
      ST_HANDSHAKE = DbgHandshake,
      ST_GET_STATUS = DbgGetStatus,
      ST_GET_REGS  = DbgGetRegs,
      ST_RECEIVING = DbgReceiving,
      ST_PRINT_REGS = DbgPrintRegs,
      ST_PAUSE     = DbgPause
   } state_type;

   // request register
   logic         req_valid_ff;
   command_type  cmd_ff;
   byte_type     data_ff;
   reg_sel_type  sel_ff;
   logic         gated_ff;

   // session state
   state_type      state_ff, state_in;
   byte_index_type byte_index_ff, byte_index_in;
   byte_type       status_ff, status_in;
   logic           paused_shown_ff, paused_shown_in;
   reg_word_type   regs_ff [NumRegs];

   // response register
   logic          rsp_valid_ff;
   code_type      port_ff, nmi_ff, irq_ff, msg_ff;
   reg_word_type  reg_value_ff;
   logic          done_ff;

   code_type      port_in, nmi_in, irq_in, msg_in;
   logic          done_in;
   reg_word_type  reg_value_in;

   logic          advance;
   logic          wr_lo_en, wr_hi_en;
   reg_sel_type   wr_addr;
   byte_index_type idx_m1;
   state_type     status_next;

   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   assign idx_m1  = byte_index_ff - 5'd1;
   assign wr_addr = idx_m1[4:1];

   always_comb begin
      unique case (data_ff) inside
         StatusDumpRegs: status_next = ST_GET_REGS;
         StatusStopped, StatusBreakpoint, StatusFinished: status_next = ST_PAUSE;
         default: status_next = ST_NONE;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      byte_index_in   = byte_index_ff;
      status_in       = status_ff;
      paused_shown_in = paused_shown_ff;
      port_in         = PortNone;
      nmi_in          = NmiNone;
      irq_in          = IrqKeep;
      msg_in          = MsgNone;
      done_in         = 1'b0;
      wr_lo_en        = 1'b0;
      wr_hi_en        = 1'b0;

      unique case (cmd_ff)
         CmdHalt: begin
            if (!gated_ff && state_ff == ST_NONE) begin
               irq_in        = IrqDisable;
               state_in      = ST_HANDSHAKE;
               byte_index_in = '0;
               nmi_in        = NmiHold;
            end
         end
         CmdBreak: begin
            if (!gated_ff) begin
               irq_in        = IrqDisable;
               state_in      = ST_PAUSE;
               byte_index_in = '0;
               nmi_in        = NmiPulse;
            end
         end
         CmdContinue: begin
            if (state_ff != ST_NONE) begin
               state_in = ST_NONE;
               nmi_in   = NmiHold;
            end
         end
         CmdReport: begin
            if (!gated_ff) begin
               if (state_ff == ST_NONE) begin
                  irq_in = IrqDisable;
               end
               state_in      = ST_GET_REGS;
               byte_index_in = '0;
               nmi_in        = NmiPulse;
            end
         end
         CmdPortRead: begin
            if (state_ff == ST_HANDSHAKE) begin
               port_in  = PortGetStatus;
               state_in = ST_GET_STATUS;
            end else if (state_ff == ST_GET_REGS) begin
               port_in       = PortDumpRegs;
               state_in      = ST_RECEIVING;
               byte_index_in = 5'd1;
            end else if (state_ff == ST_NONE) begin
               irq_in = IrqEnable;
            end else begin
               port_in = PortPause;
            end
         end
         CmdPortWr: begin
            if (state_ff == ST_GET_STATUS) begin
               status_in = data_ff;
               state_in  = status_next;
            end else if (state_ff == ST_RECEIVING) begin
               if (byte_index_ff == '0 || byte_index_ff > LastByte) begin
                  byte_index_in = '0;
               end else begin
                  // odd index: low byte, high cleared; even index: high byte only
                  wr_lo_en = byte_index_ff[0];
                  wr_hi_en = !byte_index_ff[0];
                  if (byte_index_ff == LastByte) begin
                     byte_index_in = '0;
                     state_in      = ST_PRINT_REGS;
                     done_in       = 1'b1;
                  end else begin
                     byte_index_in = byte_index_ff + 5'd1;
                  end
               end
            end
         end
         CmdPoll: begin
            if (state_ff == ST_PRINT_REGS) begin
               msg_in   = MsgRegsReady;
               state_in = ST_PAUSE;
            end else if (state_ff == ST_PAUSE) begin
               if (!paused_shown_ff) begin
                  msg_in          = MsgPaused;
                  paused_shown_in = 1'b1;
               end
            end else if (state_ff == ST_NONE) begin
               if (paused_shown_ff) begin
                  msg_in          = MsgRunning;
                  paused_shown_in = 1'b0;
               end
            end
         end
         CmdQuery: begin
         end
      endcase
   end

   // selected register as it stands after this request's write
   always_comb begin
      reg_value_in = '0;
      if (sel_ff < 4'(NumRegs)) begin
         reg_value_in = regs_ff[sel_ff];
         if (wr_addr == sel_ff) begin
            if (wr_lo_en) begin
               reg_value_in = {8'h00, data_ff};
            end else if (wr_hi_en) begin
               reg_value_in[15:8] = data_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff        <= ST_NONE;
         byte_index_ff   <= '0;
         status_ff       <= '0;
         paused_shown_ff <= 1'b0;
         for (int i = 0; i < NumRegs; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            state_ff        <= state_in;
            byte_index_ff   <= byte_index_in;
            status_ff       <= status_in;
            paused_shown_ff <= paused_shown_in;
            if (wr_lo_en) begin
               regs_ff[wr_addr] <= {8'h00, data_ff};
            end
            if (wr_hi_en) begin
               regs_ff[wr_addr][15:8] <= data_ff;
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         cmd_ff   <= req_chan.command;
         data_ff  <= req_chan.data_byte;
         sel_ff   <= req_chan.reg_select;
         gated_ff <= req_chan.reset_active || req_chan.bus_acquiring;
      end
      if (advance) begin
         port_ff      <= port_in;
         nmi_ff       <= nmi_in;
         irq_ff       <= irq_in;
         msg_ff       <= msg_in;
         reg_value_ff <= reg_value_in;
         done_ff      <= done_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.port_data    = port_ff;
   assign rsp_chan.nmi_action   = nmi_ff;
   assign rsp_chan.irq_action   = irq_ff;
   assign rsp_chan.message      = msg_ff;
   assign rsp_chan.status_byte  = status_ff;
   assign rsp_chan.reg_value    = reg_value_ff;
   assign rsp_chan.debug_state  = dbg_state_type'(state_ff);
   assign rsp_chan.capture_done = done_ff;

endmodule

### rtl/core/cdhc_checker.sv
// Port checker of the debug-port controller and its bind.
`include "cpu_debug_handshake_controller_macros.svh"

module cdhc_checker import cdhc_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          valid,
   input logic          ready,
   input code_type      port,
   input code_type      nmi,
   input code_type      msg,
   input dbg_state_type state,
   input logic          done
);

   logic stalled;
   logic done_shown;
   logic status_cmd;
   logic hold_nmi;
   logic regs_msg;
   logic hold_ok;

   assign stalled    = valid && !ready;
   assign done_shown = valid && done;
   assign status_cmd = valid && port == PortGetStatus;
   assign hold_nmi   = valid && nmi == NmiHold;
   assign regs_msg   = valid && msg == MsgRegsReady;
   // a held NMI comes from a halt or a continue
   assign hold_ok    = state == DbgHandshake || state == DbgNone;

   `CDHC_ASSERT(a_rsp_hold, stalled |=> valid, "response dropped while stalled")
   `CDHC_ASSERT(a_done_state, done_shown |-> state == DbgPrintRegs, "capture done outside print")
   `CDHC_ASSERT(a_status_read, status_cmd |-> state == DbgGetStatus, "status command off state")
   `CDHC_ASSERT(a_hold_nmi, hold_nmi |-> hold_ok, "held NMI in wrong state")
   `CDHC_ASSERT(a_regs_msg, regs_msg |-> state == DbgPause, "registers message without pause")

endmodule

bind cpu_debug_handshake_controller cdhc_checker u_cdhc_checker (
   .clock (clock),
   .reset (reset),
   .valid (rsp_chan.valid),
   .ready (rsp_chan.ready),
   .port  (rsp_chan.port_data),
   .nmi   (rsp_chan.nmi_action),
   .msg   (rsp_chan.message),
   .state (rsp_chan.debug_state),
   .done  (rsp_chan.capture_done)
);
